FILE: design/asc_pkg.sv
`timescale 1ns / 1ps
// Package for the converter scan and calibration block.
// Holds opcodes, fixed-point widths, the pipeline enable type and the mux code table.
package asc_pkg;

    // Item kinds carried on the input channel.
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_SAMPLE    = 2'd0;
    localparam t_opcode OP_WR_GAIN   = 2'd1;
    localparam t_opcode OP_WR_OFFSET = 2'd2;

    // Field widths.
    localparam int CH_W      = 6;
    localparam int RAW_W     = 16;
    localparam int COEF_W    = 32;
    localparam int MUX_W     = 8;
    localparam int MAG_W     = 13;
    localparam int CODE_W    = MAG_W + 1;
    localparam int PROD_W    = CODE_W + COEF_W;
    localparam int FRAC_DROP = 8;
    localparam int SCALED_W  = PROD_W - FRAC_DROP;
    localparam int SUM_W     = SCALED_W + 1;

    // Default channel count and coefficient reset values.
    localparam int NUM_CHANNELS_DEF = 33;
    localparam logic [COEF_W-1:0] GAIN_ONE   = 32'h0100_0000;
    localparam logic [COEF_W-1:0] OFFSET_ZERO = 32'h0000_0000;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(128);

    // Saturation limits of the Q16.16 result.
    localparam logic [COEF_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] SAT_NEG = 32'h8000_0000;

    // Multiplexer select byte per channel; channels past the table select zero.
    localparam int MUX_LEN = 33;
    localparam logic [MUX_W-1:0] MUX_CODES [MUX_LEN] = '{
        8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86,
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
        8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
        8'h87, 8'h47, 8'h27, 8'h17, 8'h00
    };

    // Stage load enables from the pipeline control to the datapath.
    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } t_pipe_en;

    function automatic logic [MUX_W-1:0] mux_of(input logic [CH_W-1:0] ch);
        logic [MUX_W-1:0] code;
        code = '0;
        if (32'(ch) < MUX_LEN) begin
            code = MUX_CODES[ch];
        end
        return code;
    endfunction

endpackage

FILE: design/asc_coeff_store.sv
`timescale 1ns / 1ps
// Gain and offset tables, one entry per channel, with registered read.
// Depends on asc_pkg; entries never written read as gain one and offset zero.
module asc_coeff_store import asc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int IDX_W        = $clog2(NUM_CHANNELS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_gain_we,
    input  logic              i_offset_we,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [COEF_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [COEF_W-1:0] o_gain,
    output logic [COEF_W-1:0] o_offset
);

    logic [COEF_W-1:0] r_gain_mem   [NUM_CHANNELS];
    logic [COEF_W-1:0] r_offset_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_gain_vld;
    logic [NUM_CHANNELS-1:0] r_offset_vld;
    logic [COEF_W-1:0] r_rd_gain;
    logic [COEF_W-1:0] r_rd_offset;
    logic              r_rd_gain_vld;
    logic              r_rd_offset_vld;

    // Per-entry written flags; reset returns every entry to its default.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_vld   <= '0;
            r_offset_vld <= '0;
        end else begin
            if (i_gain_we) begin
                r_gain_vld[i_wr_addr] <= 1'b1;
            end
            if (i_offset_we) begin
                r_offset_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Table write port.
    always_ff @(posedge i_clk) begin
        if (i_gain_we) begin
            r_gain_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_offset_we) begin
            r_offset_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read of the scanned channel's entries.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_gain       <= r_gain_mem[i_rd_addr];
            r_rd_offset     <= r_offset_mem[i_rd_addr];
            r_rd_gain_vld   <= r_gain_vld[i_rd_addr];
            r_rd_offset_vld <= r_offset_vld[i_rd_addr];
        end
    end

    assign o_gain   = r_rd_gain_vld ? r_rd_gain : GAIN_ONE;
    assign o_offset = r_rd_offset_vld ? r_rd_offset : OFFSET_ZERO;

endmodule

FILE: design/asc_cal_datapath.sv
`timescale 1ns / 1ps
// Decode, gain multiply, rounding, offset add and saturation over two stages.
// Depends on asc_pkg; stage loads come from the top-level pipeline control.
module asc_cal_datapath import asc_pkg::*; (
    input  logic                     i_clk,
    input  t_pipe_en                 i_en,
    input  logic                     i_sample,
    input  logic                     i_read_ok,
    input  logic [RAW_W-1:0]         i_raw_word,
    input  logic [CH_W-1:0]          i_channel,
    input  logic [MUX_W-1:0]         i_mux_code,
    input  logic [COEF_W-1:0]        i_gain,
    input  logic [COEF_W-1:0]        i_offset,
    output logic [CH_W-1:0]          o_channel,
    output logic signed [COEF_W-1:0] o_calibrated_value,
    output logic                     o_value_valid,
    output logic [MUX_W-1:0]         o_next_mux_code
);

    logic [MAG_W-1:0]         w_neg_mag;
    logic signed [CODE_W-1:0] w_code;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_word_ok;

    logic signed [PROD_W-1:0] r_b_prod;
    logic [COEF_W-1:0]        r_b_offset;
    logic                     r_b_valid;
    logic [CH_W-1:0]          r_b_channel;
    logic [MUX_W-1:0]         r_b_mux;

    logic signed [PROD_W-1:0]   w_rounded;
    logic signed [SCALED_W-1:0] w_scaled;
    logic signed [SUM_W-1:0]    w_sum;
    logic                       w_in_range;
    logic [COEF_W-1:0]          w_value;

    // Word check and sign-magnitude decode; a set sign bit with zero low bits gives zero.
    assign w_word_ok = i_sample && i_read_ok && (i_raw_word[RAW_W-1:RAW_W-2] == 2'b00);
    assign w_neg_mag = MAG_W'(0) - i_raw_word[MAG_W-1:0];
    assign w_code    = i_raw_word[MAG_W] ? -$signed({1'b0, w_neg_mag})
                                         : $signed({1'b0, i_raw_word[MAG_W-1:0]});
    assign w_prod    = w_code * $signed(i_gain);

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (i_en.ld_b) begin
            r_b_prod    <= w_prod;
            r_b_offset  <= i_offset;
            r_b_valid   <= w_word_ok;
            r_b_channel <= i_channel;
            r_b_mux     <= i_mux_code;
        end
    end

    // Round half up to Q16.16, add offset, clamp to 32 bits.
    assign w_rounded  = r_b_prod + $signed(ROUND_HALF);
    assign w_scaled   = w_rounded[PROD_W-1:FRAC_DROP];
    assign w_sum      = SUM_W'(w_scaled) + SUM_W'($signed(r_b_offset));
    assign w_in_range = (&w_sum[SUM_W-1:COEF_W-1]) || !(|w_sum[SUM_W-1:COEF_W-1]);
    always_comb begin
        if (!r_b_valid) begin
            w_value = '0;
        end else if (w_in_range) begin
            w_value = w_sum[COEF_W-1:0];
        end else begin
            w_value = w_sum[SUM_W-1] ? SAT_NEG : SAT_POS;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_en.ld_c) begin
            o_calibrated_value <= $signed(w_value);
            o_value_valid      <= r_b_valid;
            o_channel          <= r_b_channel;
            o_next_mux_code    <= r_b_mux;
        end
    end

endmodule

FILE: design/adc_scan_calibrate.sv
`timescale 1ns / 1ps
// Top level of the converter scan and calibration block.
// Depends on asc_pkg, asc_coeff_store and asc_cal_datapath.
//
//  Channel  Direction  Handshake            Word
//  input    in         i_valid / o_stall    opcode, raw word, read flag, coeff index/value
//  output   out        o_valid / i_stall    channel, calibrated value, valid flag, mux code
//
// One word is accepted per cycle while o_stall is low; each result passes through the
// table read, product and result register stages.
// Reset clears the scan channel to 0, the pipeline valids and the table written
// flags, so every table entry reads as gain one and offset zero; no clearing pass.
// A stalled output holds its word; stall backs up through the three stages and
// o_stall rises only when all of them are full.
module adc_scan_calibrate import asc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_opcode,
    input  logic [RAW_W-1:0]         i_raw_word,
    input  logic                     i_read_ok,
    input  logic [CH_W-1:0]          i_coeff_index,
    input  logic signed [COEF_W-1:0] i_coeff_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CH_W-1:0]          o_channel,
    output logic signed [COEF_W-1:0] o_calibrated_value,
    output logic                     o_value_valid,
    output logic [MUX_W-1:0]         o_next_mux_code
);

    localparam int IDX_W = $clog2(NUM_CHANNELS);

    logic             r_a_vld;
    logic             r_b_vld;
    logic             r_c_vld;
    logic [IDX_W-1:0] r_scan;
    logic [IDX_W-1:0] n_scan;

    logic             r_a_sample;
    logic             r_a_read_ok;
    logic [RAW_W-1:0] r_a_raw;
    logic [CH_W-1:0]  r_a_channel;
    logic [MUX_W-1:0] r_a_mux;

    logic              w_rdy_a;
    logic              w_rdy_b;
    logic              w_rdy_c;
    logic              w_accept;
    logic              w_is_sample;
    logic              w_idx_ok;
    logic [COEF_W-1:0] w_gain;
    logic [COEF_W-1:0] w_offset;
    t_pipe_en          w_en;

    // Pipeline flow control: a stage loads when it is empty or the one after it frees up.
    assign w_rdy_c  = !r_c_vld || !i_stall;
    assign w_rdy_b  = !r_b_vld || w_rdy_c;
    assign w_rdy_a  = !r_a_vld || w_rdy_b;
    assign w_accept = i_valid && w_rdy_a;
    assign o_stall  = !w_rdy_a;
    assign o_valid  = r_c_vld;

    assign w_en.ld_a = w_accept;
    assign w_en.ld_b = w_rdy_b;
    assign w_en.ld_c = w_rdy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_vld <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_vld <= r_a_vld;
            end
            if (w_rdy_c) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    // Round-robin scan pointer; only sample words move it.
    assign w_is_sample = (i_opcode == OP_SAMPLE);
    assign n_scan = (r_scan == IDX_W'(NUM_CHANNELS - 1)) ? '0 : r_scan + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (w_accept && w_is_sample) begin
            r_scan <= n_scan;
        end
    end

    // Input stage register, loaded alongside the table read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_sample  <= w_is_sample;
            r_a_read_ok <= i_read_ok;
            r_a_raw     <= i_raw_word;
            r_a_channel <= CH_W'(r_scan);
            r_a_mux     <= mux_of(CH_W'(w_is_sample ? n_scan : r_scan));
        end
    end

    // Coefficient writes land at accept, so a later sample always sees them.
    assign w_idx_ok = ({1'b0, i_coeff_index} < (CH_W + 1)'(NUM_CHANNELS));

    asc_coeff_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain_we   (w_accept && w_idx_ok && (i_opcode == OP_WR_GAIN)),
        .i_offset_we (w_accept && w_idx_ok && (i_opcode == OP_WR_OFFSET)),
        .i_wr_addr   (i_coeff_index[IDX_W-1:0]),
        .i_wr_data   (i_coeff_value),
        .i_rd_en     (w_en.ld_a),
        .i_rd_addr   (r_scan),
        .o_gain      (w_gain),
        .o_offset    (w_offset)
    );

    asc_cal_datapath u_dp (
        .i_clk              (i_clk),
        .i_en               (w_en),
        .i_sample           (r_a_sample),
        .i_read_ok          (r_a_read_ok),
        .i_raw_word         (r_a_raw),
        .i_channel          (r_a_channel),
        .i_mux_code         (r_a_mux),
        .i_gain             (w_gain),
        .i_offset           (w_offset),
        .o_channel          (o_channel),
        .o_calibrated_value (o_calibrated_value),
        .o_value_valid      (o_value_valid),
        .o_next_mux_code    (o_next_mux_code)
    );

    // The input side stalls only when the output word is held.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output stage could move");

    // The scan pointer never leaves the channel range.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_scan) < NUM_CHANNELS))
        else $error("scan channel out of range");

    // A rejected sample or a table write shows a zero value.
    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_value_valid) |-> (o_calibrated_value == '0))
        else $error("nonzero value on an invalid result");

    // Table writes and unused opcodes leave the scan where it is.
    a_write_holds_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_sample) |=> $stable(r_scan))
        else $error("scan moved on a non-sample word");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for adc_scan_calibrate: drives sample and coefficient words, predicts each
// result word with a scoreboard class and checks the output. Depends on asc_pkg.
module tb_top;
    import asc_pkg::*;

    localparam int NCH = 33;
    localparam int CLK_PERIOD = 12;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int HOLD_CYCLES = 60;

    // The one opcode the package leaves unnamed; the block treats it as a no-op.
    localparam t_opcode OP_SPARE = 2'd3;

    // Expected contents of one result word.
    typedef struct {
        logic [CH_W-1:0]          channel;
        logic signed [COEF_W-1:0] value;
        logic                     value_valid;
        logic [MUX_W-1:0]         mux;
    } t_cal_result;

    // Scanner model: tracks the scan position and both coefficient tables, and queues
    // the calibrated result each accepted word should produce.
    class scan_checker;
        logic [CH_W-1:0]          scan_ch;
        logic signed [COEF_W-1:0] gain_q824 [NCH];
        logic signed [COEF_W-1:0] offset_q1616 [NCH];
        t_cal_result              pending_cal [$];
        int                       fail_count;

        function new();
            scan_ch = '0;
            fail_count = 0;
            for (int i = 0; i < NCH; i++) begin
                gain_q824[i] = 32'sh0100_0000;
                offset_q1616[i] = '0;
            end
        endfunction

        // Multiplexer select byte of a channel; channels past the list select zero.
        function logic [MUX_W-1:0] mux_sel(input logic [CH_W-1:0] ch);
            logic [MUX_W-1:0] codes [33];
            codes = '{8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86,
                      8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
                      8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
                      8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
                      8'h87, 8'h47, 8'h27, 8'h17, 8'h00};
            if (ch < 33) begin
                return codes[ch];
            end
            return '0;
        endfunction

        // Work out the result of one accepted word and update the model state.
        function void note_word(input t_opcode op, input logic [RAW_W-1:0] raw,
                                input logic ok, input logic [CH_W-1:0] idx,
                                input logic signed [COEF_W-1:0] cv);
            t_cal_result      r;
            logic [CH_W-1:0]  ch;
            logic [CH_W-1:0]  nxt;
            logic [RAW_W-1:0] neg_raw;
            longint           code;
            longint           acc;
            ch = (scan_ch >= NCH) ? '0 : scan_ch;
            r.channel = ch;
            r.value = '0;
            r.value_valid = 1'b0;
            r.mux = mux_sel(ch);
            case (op)
                OP_SAMPLE: begin
                    nxt = (ch == NCH - 1) ? '0 : ch + 1'b1;
                    r.value_valid = ok && (raw[15:14] == 2'b00);
                    if (r.value_valid) begin
                        // Bit 13 is the sign; the magnitude of a negative word comes
                        // from its two's complement, so the bare sign bit reads zero.
                        neg_raw = -raw;
                        if (raw[13]) begin
                            code = -longint'(neg_raw[12:0]);
                        end else begin
                            code = longint'(raw[12:0]);
                        end
                        // Q.24 product rounded half up to Q16.16, then offset, saturate.
                        acc = ((code * longint'(gain_q824[ch]) + 128) >>> 8)
                              + longint'(offset_q1616[ch]);
                        if (acc > Q_MAX) begin
                            acc = Q_MAX;
                        end else if (acc < Q_MIN) begin
                            acc = Q_MIN;
                        end
                        r.value = acc[31:0];
                    end
                    scan_ch = nxt;
                    r.mux = mux_sel(nxt);
                end
                OP_WR_GAIN: begin
                    if (idx < NCH) begin
                        gain_q824[idx] = cv;
                    end
                end
                OP_WR_OFFSET: begin
                    if (idx < NCH) begin
                        offset_q1616[idx] = cv;
                    end
                end
                default: begin
                end
            endcase
            pending_cal.push_back(r);
        endfunction

        // Print one mismatch line and count it.
        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            fail_count++;
        endtask

        // Compare an accepted result word with the oldest pending expectation.
        task check_word(input logic [CH_W-1:0] ch, input logic signed [COEF_W-1:0] val,
                        input logic vv, input logic [MUX_W-1:0] mux);
            t_cal_result e;
            if (pending_cal.size() == 0) begin
                report($sformatf("result word with nothing pending, channel %0d", ch));
            end else begin
                e = pending_cal.pop_front();
                if (ch !== e.channel) begin
                    report($sformatf("channel %0d, expected %0d", ch, e.channel));
                end
                if (val !== e.value) begin
                    report($sformatf("calibrated value %h, expected %h on channel %0d",
                                     val, e.value, e.channel));
                end
                if (vv !== e.value_valid) begin
                    report($sformatf("value valid %b, expected %b on channel %0d",
                                     vv, e.value_valid, e.channel));
                end
                if (mux !== e.mux) begin
                    report($sformatf("next mux code %h, expected %h on channel %0d",
                                     mux, e.mux, e.channel));
                end
            end
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [1:0]               i_opcode;
    logic [RAW_W-1:0]         i_raw_word;
    logic                     i_read_ok;
    logic [CH_W-1:0]          i_coeff_index;
    logic signed [COEF_W-1:0] i_coeff_value;
    logic                     o_valid;
    logic                     i_stall;
    logic [CH_W-1:0]          o_channel;
    logic signed [COEF_W-1:0] o_calibrated_value;
    logic                     o_value_valid;
    logic [MUX_W-1:0]         o_next_mux_code;

    scan_checker sb = new();
    int          words_sent = 0;
    bit          hold_req = 1'b0;

    adc_scan_calibrate #(.NUM_CHANNELS(NCH)) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_raw_word         (i_raw_word),
        .i_read_ok          (i_read_ok),
        .i_coeff_index      (i_coeff_index),
        .i_coeff_value      (i_coeff_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_channel          (o_channel),
        .o_calibrated_value (o_calibrated_value),
        .o_value_valid      (o_value_valid),
        .o_next_mux_code    (o_next_mux_code)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // Offer one word after an optional random gap and wait until it is accepted.
    task automatic send_word(input t_opcode op, input logic [RAW_W-1:0] raw,
                             input logic ok, input logic [CH_W-1:0] idx,
                             input logic signed [COEF_W-1:0] cv);
        bit tx_quiet;
        tx_quiet = (words_sent >= 500) && (words_sent < 800);
        while (!tx_quiet && ($urandom_range(99) < 16)) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_raw_word    <= raw;
        i_read_ok     <= ok;
        i_coeff_index <= idx;
        i_coeff_value <= cv;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.note_word(op, raw, ok, idx, cv);
        words_sent++;
        if (words_sent == 520) begin
            hold_req = 1'b1;
        end
    endtask

    // Build one random word: mostly samples of well-formed converter words, with
    // coefficient loads, junk words, failed reads and the spare opcode mixed in.
    task automatic send_random_word();
        t_opcode                  op;
        logic [RAW_W-1:0]         raw;
        logic                     ok;
        logic [CH_W-1:0]          idx;
        logic signed [COEF_W-1:0] cv;
        int                       pick;
        logic [RAW_W-1:0]         edge_words [6];
        edge_words = '{16'h0000, 16'h0001, 16'h1FFF, 16'h2000, 16'h2001, 16'h3FFF};
        pick = $urandom_range(99);
        if (pick < 70) begin
            op = OP_SAMPLE;
        end else if (pick < 82) begin
            op = OP_WR_GAIN;
        end else if (pick < 94) begin
            op = OP_WR_OFFSET;
        end else begin
            op = OP_SPARE;
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
            raw = {2'b00, 14'($urandom_range(16383))};
        end else if (pick < 65) begin
            raw = edge_words[$urandom_range(5)];
        end else begin
            raw = 16'($urandom);
        end
        ok = ($urandom_range(99) < 92);
        idx = ($urandom_range(99) < 85) ? 6'($urandom_range(NCH - 1))
                                         : 6'($urandom_range(63, NCH));
        pick = $urandom_range(99);
        if (pick < 45) begin
            // Gain within about +-4.0 or offset within about +-1024.0.
            cv = (op == OP_WR_GAIN) ? 32'(int'($urandom_range(134217728)) - 67108864)
                                    : 32'(int'($urandom_range(134217728)) - 67108864);
        end else if (pick < 55) begin
            cv = ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end else begin
            cv = 32'($urandom);
        end
        send_word(op, raw, ok, idx, cv);
    endtask

    // Output side stalls at random, holds off once for a long stretch to back the
    // pipeline up, and stays quiet for a while afterwards.
    initial begin : rx_ctl
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (words_sent >= 600 && words_sent < 800) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 16);
            end
        end
    end

    // Check every result word the output channel accepts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word(o_channel, o_calibrated_value, o_value_valid, o_next_mux_code);
        end
    end

    // Directed words, random words, then drain and decide.
    initial begin : stim
        int n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_SAMPLE;
        i_raw_word = '0;
        i_read_ok = 1'b0;
        i_coeff_index = '0;
        i_coeff_value = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Largest gain and offset on channel 0 drive the result into positive saturation.
        send_word(OP_WR_GAIN, 16'h0000, 1'b0, 6'd0, 32'sh7FFF_FFFF);
        send_word(OP_WR_OFFSET, 16'hFFFF, 1'b1, 6'd0, 32'sh7FFF_FFFF);
        send_word(OP_SAMPLE, 16'h1FFF, 1'b1, 6'd0, 32'sh0);
        // Most negative gain and offset on channel 1 saturate the other way.
        send_word(OP_WR_GAIN, 16'h0000, 1'b0, 6'd1, 32'sh8000_0000);
        send_word(OP_WR_OFFSET, 16'h0000, 1'b0, 6'd1, 32'sh8000_0000);
        send_word(OP_SAMPLE, 16'h1FFF, 1'b1, 6'd63, 32'sh0);
        // Decoding at unity gain: zero, bare sign bit, largest negative, minus one.
        send_word(OP_SAMPLE, 16'h0000, 1'b1, 6'd0, 32'sh0);
        send_word(OP_SAMPLE, 16'h2000, 1'b1, 6'd0, 32'sh0);
        send_word(OP_SAMPLE, 16'h2001, 1'b1, 6'd0, 32'sh0);
        send_word(OP_SAMPLE, 16'h3FFF, 1'b1, 6'd0, 32'sh0);
        // Rejected samples: upper bits set, or the serial read failed.
        send_word(OP_SAMPLE, 16'h4000, 1'b1, 6'd0, 32'sh0);
        send_word(OP_SAMPLE, 16'h8000, 1'b1, 6'd0, 32'sh0);
        send_word(OP_SAMPLE, 16'hFFFF, 1'b1, 6'd0, 32'sh0);
        send_word(OP_SAMPLE, 16'h1234, 1'b0, 6'd0, 32'sh0);
        // Last entry, out-of-range indexes and the spare opcode.
        send_word(OP_WR_GAIN, 16'h0000, 1'b0, 6'd32, 32'sh0080_0000);
        send_word(OP_WR_OFFSET, 16'h0000, 1'b0, 6'd32, -32'sh0001_8000);
        send_word(OP_WR_GAIN, 16'h0000, 1'b0, 6'd33, 32'sh0000_0000);
        send_word(OP_WR_OFFSET, 16'h0000, 1'b0, 6'd63, 32'sh7FFF_FFFF);
        send_word(OP_SPARE, 16'hFFFF, 1'b1, 6'd5, 32'shFFFF_FFFF);
        // Rounding: a tiny gain on the channel scanned next leaves only the
        // half-up rounding of the product.
        send_word(OP_WR_GAIN, 16'h0000, 1'b0, 6'd10, 32'sh0000_0001);
        send_word(OP_SAMPLE, 16'h0080, 1'b1, 6'd0, 32'sh0);
        send_word(OP_SAMPLE, 16'h1000, 1'b1, 6'd0, 32'sh0);

        for (n = 0; n < 1330; n++) begin
            send_random_word();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain the pipeline, then allow a few more cycles for stray words.
        for (n = 0; n < 20000 && sb.pending_cal.size() > 0; n++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending_cal.size() > 0) begin
            sb.report($sformatf("%0d result words never arrived", sb.pending_cal.size()));
        end
        if (sb.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("Some tests failed");
        $finish;
    end

endmodule
